// ----- rtl/core/cmvp_pkg.sv -----
// Shared types, constants and helpers for the CSR matrix multi-vector product block.
`default_nettype none

package cmvp_pkg;

  localparam int MAX_ENTITIES = 4096;
  localparam int MAX_DIM      = 3;
  localparam int ENT_W        = $clog2(MAX_ENTITIES);
  localparam int DIM_W        = 2;
  localparam int COMP_W       = 32;
  localparam int ACC_W        = 64;
  localparam int FRAC_W       = 16;

  typedef enum logic [1:0] {
    ACT_LOAD      = 2'd0,
    ACT_NONZERO   = 2'd1,
    ACT_EMPTY_ROW = 2'd2,
    ACT_START     = 2'd3
  } action_t;

  typedef logic [COMP_W-1:0]            comp_t;
  typedef comp_t [MAX_DIM-1:0]          comp_vec_t;
  typedef logic [ACC_W-1:0]             acc_t;
  typedef acc_t [MAX_DIM-1:0]           acc_vec_t;

  typedef struct packed {
    action_t              action;
    logic [ENT_W-1:0]     entity_index;
    logic signed [31:0]   load_comp0;
    logic signed [31:0]   load_comp1;
    logic signed [31:0]   load_comp2;
    logic [ENT_W-1:0]     column_index;
    logic signed [31:0]   matrix_value;
    logic                 row_end;
  } item_t;

  typedef struct packed {
    logic [ENT_W-1:0]     row_number;
    logic signed [31:0]   out_comp0;
    logic signed [31:0]   out_comp1;
    logic signed [31:0]   out_comp2;
    logic                 saturated;
  } result_t;

  // Per-stage control travelling down the pipe.
  typedef struct packed {
    logic    valid;
    action_t action;
    logic    row_end;
  } stage_ctrl_t;

  // A closed row waiting for output conversion.
  typedef struct packed {
    logic             valid;
    logic [ENT_W-1:0] row_number;
    acc_vec_t         acc;
    logic             saturated;
  } emit_t;

  // Components in use: dimension zero counts as one.
  function automatic logic [MAX_DIM-1:0] dim_mask(input logic [DIM_W-1:0] dim);
    logic [MAX_DIM-1:0] m;
    unique case (dim) inside
      2'd0, 2'd1: m = 3'b001;
      2'd2:       m = 3'b011;
      default:    m = 3'b111;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cmvp_vec_store.sv -----
// Entity vector store: one word per entity, per-component write lanes, registered read.
`default_nettype none

module cmvp_vec_store
  import cmvp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [MAX_DIM-1:0] wr_lane,
  input  wire logic [ENT_W-1:0]   wr_addr,
  input  wire comp_vec_t          wr_data,
  input  wire logic               rd_en,
  input  wire logic [ENT_W-1:0]   rd_addr,
  output comp_vec_t               rd_data
);

  comp_vec_t mem [MAX_ENTITIES];

  always_ff @(posedge clk) begin
    for (int d = 0; d < MAX_DIM; d++) begin
      if (wr_lane[d]) begin
        mem[wr_addr][d] <= wr_data[d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cmvp_mac.sv -----
// Multiply stage, saturating row accumulators, row counter and row close.
`default_nettype none

module cmvp_mac
  import cmvp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic [DIM_W-1:0] dim,
  input  wire stage_ctrl_t      s1_ctrl,
  input  wire comp_t            s1_mval,
  input  wire comp_vec_t        s1_vec,
  output emit_t                 emit
);

  stage_ctrl_t        s2_ctrl;
  acc_vec_t           prod;
  acc_vec_t           acc;
  acc_vec_t           acc_next;
  acc_vec_t           acc_sum;
  logic [MAX_DIM-1:0] ovf;
  logic [MAX_DIM-1:0] mask;
  logic [ENT_W-1:0]   row;
  logic [ENT_W-1:0]   row_next;
  logic               flag;
  logic               flag_next;
  logic               do_emit;
  emit_t              emit_next;

  // Stage 2: one 32x32 signed product per component.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctrl.valid <= 1'b0;
    end else if (en) begin
      s2_ctrl.valid <= s1_ctrl.valid;
    end
    if (en) begin
      s2_ctrl.action  <= s1_ctrl.action;
      s2_ctrl.row_end <= s1_ctrl.row_end;
      for (int d = 0; d < MAX_DIM; d++) begin
        prod[d] <= ACC_W'($signed(s1_mval) * $signed(s1_vec[d]));
      end
    end
  end

  assign mask = dim_mask(dim);

  // Stage 3: saturating add, then row bookkeeping.
  always_comb begin
    for (int d = 0; d < MAX_DIM; d++) begin
      acc_sum[d] = acc[d] + prod[d];
      ovf[d]     = (acc[d][ACC_W-1] == prod[d][ACC_W-1]) &&
                   (acc_sum[d][ACC_W-1] != acc[d][ACC_W-1]);
      if (ovf[d]) begin
        acc_sum[d] = prod[d][ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                      : {1'b0, {(ACC_W-1){1'b1}}};
      end
    end

    acc_next  = acc;
    flag_next = flag;
    row_next  = row;
    do_emit   = 1'b0;

    if (s2_ctrl.valid) begin
      unique case (s2_ctrl.action)
        ACT_NONZERO: begin
          for (int d = 0; d < MAX_DIM; d++) begin
            if (mask[d]) begin
              acc_next[d] = acc_sum[d];
            end
          end
          flag_next = flag | (|(ovf & mask));
          do_emit   = s2_ctrl.row_end;
        end
        ACT_EMPTY_ROW: begin
          do_emit = 1'b1;
        end
        ACT_START: begin
          acc_next  = '0;
          flag_next = 1'b0;
          row_next  = '0;
        end
        ACT_LOAD: begin
        end
      endcase
    end

    emit_next.valid      = do_emit;
    emit_next.row_number = row;
    emit_next.acc        = acc_next;
    emit_next.saturated  = flag_next;

    if (do_emit) begin
      acc_next  = '0;
      flag_next = 1'b0;
      row_next  = row + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      flag       <= 1'b0;
      row        <= '0;
      emit.valid <= 1'b0;
    end else if (en) begin
      acc        <= acc_next;
      flag       <= flag_next;
      row        <= row_next;
      emit.valid <= emit_next.valid;
    end
    if (en) begin
      emit.row_number <= emit_next.row_number;
      emit.acc        <= emit_next.acc;
      emit.saturated  <= emit_next.saturated;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cmvp_emit.sv -----
// Q32.32 to Q16.16 conversion with saturation and the result register.
`default_nettype none

module cmvp_emit
  import cmvp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic [DIM_W-1:0] dim,
  input  wire emit_t            emit,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output result_t               result
);

  logic [MAX_DIM-1:0] mask;
  comp_vec_t          q;
  logic [MAX_DIM-1:0] q_sat;
  result_t            result_next;

  assign mask = dim_mask(dim);

  always_comb begin
    for (int d = 0; d < MAX_DIM; d++) begin
      q[d]     = '0;
      q_sat[d] = 1'b0;
      if (mask[d]) begin
        // Floor shift fits 32 bits only if the top bits are pure sign.
        if (emit.acc[d][ACC_W-1:COMP_W+FRAC_W-1] ==
            {(ACC_W-COMP_W-FRAC_W+1){emit.acc[d][ACC_W-1]}}) begin
          q[d] = emit.acc[d][COMP_W+FRAC_W-1:FRAC_W];
        end else begin
          q_sat[d] = 1'b1;
          q[d]     = emit.acc[d][ACC_W-1] ? {1'b1, {(COMP_W-1){1'b0}}}
                                          : {1'b0, {(COMP_W-1){1'b1}}};
        end
      end
    end
    result_next.row_number = emit.row_number;
    result_next.out_comp0  = q[0];
    result_next.out_comp1  = q[1];
    result_next.out_comp2  = q[2];
    result_next.saturated  = emit.saturated | (|q_sat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en && emit.valid) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && emit.valid) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/csr_matrix_multi_vector_product.sv -----
// Top level of the CSR sparse matrix times multi-component vector block.
`default_nettype none

// Streams a CSR matrix against a dense vector of 1 to 3 Q16.16 components per
// entity. Load transactions fill a 4096-entity vector store (4096 x 96 bits,
// one synchronous RAM with a write lane per component); reading an entity that
// was never loaded returns undefined data. A start transaction clears the row
// counter, accumulators and saturation flag; nonzero transactions multiply
// their coefficient by the stored entity and add into 64-bit Q32.32
// accumulators that saturate; a row-end nonzero or an empty-row transaction
// closes the row and produces one result transaction with Q16.16 outputs
// (floor, saturated) and a flag if anything in that row saturated.
// Throughput is one transaction per clock on any mix of actions while the pipe
// is not stopped. A closing transaction's result passes the store read and
// stage 1 at its accepting edge, then multiply, accumulate, and convert into
// the result register. The pipe only stops when a closed row reaches the
// convert stage while the result register is still held by the consumer;
// then the whole pipe stops, non-closing transactions included.
// The dimension register may only be written while the pipe is empty.

module csr_matrix_multi_vector_product
  import cmvp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [DIM_W-1:0] cfg_data,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire item_t            item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output result_t               result
);

  logic [DIM_W-1:0]   dim;
  logic               en;
  logic               accept;
  logic [MAX_DIM-1:0] wr_lane;
  comp_vec_t          wr_data;
  comp_vec_t          s1_vec;
  stage_ctrl_t        s1_ctrl;
  comp_t              s1_mval;
  emit_t              emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim <= DIM_W'(1);
    end else if (cfg_write) begin
      dim <= cfg_data;
    end
  end

  // Whole pipe advances unless a closed row is blocked by a full result register.
  assign en         = !(emit.valid && result_valid && !result_ready);
  assign item_ready = en && !rst;
  assign accept     = item_valid && item_ready;

  // Loads write at acceptance; a later nonzero reads in a later cycle, so no bypass.
  assign wr_lane = (accept && item.action == ACT_LOAD) ? dim_mask(dim) : '0;
  assign wr_data = {comp_t'(item.load_comp2), comp_t'(item.load_comp1),
                    comp_t'(item.load_comp0)};

  cmvp_vec_store u_store (
    .clk     (clk),
    .wr_lane (wr_lane),
    .wr_addr (item.entity_index),
    .wr_data (wr_data),
    .rd_en   (en),
    .rd_addr (item.column_index),
    .rd_data (s1_vec)
  );

  // Stage 1 sits alongside the store read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctrl.valid <= 1'b0;
    end else if (en) begin
      s1_ctrl.valid <= accept;
    end
    if (en) begin
      s1_ctrl.action  <= item.action;
      s1_ctrl.row_end <= item.row_end;
      s1_mval         <= comp_t'(item.matrix_value);
    end
  end

  cmvp_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .dim     (dim),
    .s1_ctrl (s1_ctrl),
    .s1_mval (s1_mval),
    .s1_vec  (s1_vec),
    .emit    (emit)
  );

  cmvp_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .dim          (dim),
    .emit         (emit),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire
